### hw/rtl/ipv4_header_generator_defines.svh
// Assertion macros for the IPv4 header generator.
// Used by the top level; relies on clk and rst being in scope.
`ifndef IPV4_HEADER_GENERATOR_DEFINES_SVH
`define IPV4_HEADER_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check an implication property on every clock edge outside reset.
`define IPV4HG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipv4hg assertion failed");
// Check a property that must also hold while reset is applied.
`define IPV4HG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipv4hg assertion failed");
`else
`define IPV4HG_ASSERT(lbl, prop)
`define IPV4HG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hw/rtl/ipv4hg_pkg.sv
// Shared types and constants of the IPv4 header generator.
// No dependencies; imported by every module of the block.
package ipv4hg_pkg;

  localparam int NumWords = 5;
  localparam int CfgIdxW  = 8;

  localparam logic [2:0]  LastIdx    = 3'd4;
  localparam logic [15:0] MaxPayload = 16'd65515;
  localparam logic [15:0] HdrBytes   = 16'd20;
  localparam logic [7:0]  VerIhl     = 8'h45;
  localparam logic [7:0]  TosValue   = 8'h00;
  localparam logic [15:0] FlagsDf    = 16'h4000;
  localparam logic [7:0]  TtlValue   = 8'd64;
  localparam logic [15:0] IdentReset = 16'd1;
  localparam logic [31:0] BcastAddr  = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLocalIp    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSubnetMask = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgGatewayIp  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgLoopback   = 8'd3;

  typedef logic [31:0] word_t;

  // One finished request: header words plus per-request flags
  typedef struct packed {
    logic [NumWords-1:0][31:0] words;
    word_t                     next_hop;
    logic                      bcast;
    logic                      err;
  } hdr_t;

endpackage

### hw/rtl/ipv4hg_hdr_build.sv
// Header builder: fields, checksum, next hop and broadcast for one request.
// Pure combinational; uses ipv4hg_pkg.
module ipv4hg_hdr_build (
  input  ipv4hg_pkg::word_t dest_addr,
  input  logic [7:0]        protocol_num,
  input  logic [15:0]       payload_len,
  input  logic [15:0]       ident,
  input  ipv4hg_pkg::word_t local_ip,
  input  ipv4hg_pkg::word_t subnet_mask,
  input  ipv4hg_pkg::word_t gateway_ip,
  input  logic              loopback_mode,
  output ipv4hg_pkg::hdr_t  hdr
);
  import ipv4hg_pkg::*;

  logic [15:0] ip_len;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;
  logic        err;

  // Total length wraps to 16 bits; it only matters when in range
  assign ip_len = payload_len + HdrBytes;
  assign err    = (payload_len > MaxPayload);

  // Add the nine nonzero header halves, then fold the carries twice
  assign sum = 20'({VerIhl, TosValue}) + 20'(ip_len) + 20'(ident) + 20'(FlagsDf)
             + 20'({TtlValue, protocol_num})
             + 20'(local_ip[31:16]) + 20'(local_ip[15:0])
             + 20'(dest_addr[31:16]) + 20'(dest_addr[15:0]);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = ~fold2;

  always_comb begin
    hdr.err      = err;
    hdr.bcast    = !loopback_mode && (dest_addr == BcastAddr);
    hdr.next_hop = dest_addr;
    if (!loopback_mode && ((dest_addr & subnet_mask) != (local_ip & subnet_mask))) begin
      hdr.next_hop = gateway_ip;
    end
    // Error results carry an all-zero word
    if (err) begin
      hdr.words = '0;
    end else begin
      hdr.words[0] = {VerIhl, TosValue, ip_len};
      hdr.words[1] = {ident, FlagsDf};
      hdr.words[2] = {TtlValue, protocol_num, csum};
      hdr.words[3] = local_ip;
      hdr.words[4] = dest_addr;
    end
  end

endmodule

### hw/rtl/ipv4hg_out_stage.sv
// Output serializer: holds one built header and sends it one word per beat.
// Uses ipv4hg_pkg.
module ipv4hg_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ipv4hg_pkg::hdr_t  hdr_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ipv4hg_pkg::word_t header_word,
  output logic [2:0]        word_index,
  output logic              last_word,
  output ipv4hg_pkg::word_t next_hop,
  output logic              dest_broadcast,
  output logic              length_error
);
  import ipv4hg_pkg::*;

  logic       valid;
  logic [2:0] idx;
  hdr_t       hdr;
  logic       accept;
  logic       is_last;

  assign accept  = valid && !out_stall;
  assign is_last = hdr.err || (idx == LastIdx);
  assign free    = !valid || (accept && is_last);

  // Load a new header, or advance one word per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (accept) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    if (load) begin
      hdr <= hdr_in;
    end
  end

  // Select the current word
  always_comb begin
    case (idx)
      3'd0:    header_word = hdr.words[0];
      3'd1:    header_word = hdr.words[1];
      3'd2:    header_word = hdr.words[2];
      3'd3:    header_word = hdr.words[3];
      3'd4:    header_word = hdr.words[4];
      default: header_word = '0;
    endcase
  end

  assign out_valid      = valid;
  assign word_index     = idx;
  assign last_word      = is_last;
  assign next_hop       = hdr.next_hop;
  assign dest_broadcast = hdr.bcast;
  assign length_error   = hdr.err;

endmodule

### hw/rtl/ipv4_header_generator.sv
// IPv4 header generator.
// Input channel (in_valid/in_stall) takes one request per beat: dest_addr,
// protocol_num, payload_len. A request lands in an input register; the
// header builder works on it there and the result moves into the output
// serializer, which sends five 32-bit header words (word_index 0..4,
// last_word on word 4) on the output channel (out_valid/out_stall), one
// per cycle while out_stall is low. A payload over 65515 bytes yields one error beat instead and
// leaves the identification counter alone.
// A request passes through the input register, then the serializer,
// before its first word is valid on the output channel.
// Throughput is set by the single output word port: a header goes out word
// by word, and an error result is a single beat. The input register takes the
// next request while the previous header is still being sent.
// Receiver stall holds the current word; in_stall is high while the input
// register is full and the serializer cannot load it.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// indexes beyond the register list are dropped. Write it only while idle.
// Reset (rst, synchronous) empties both stages, clears the registers and
// sets the identification counter to 1.
module ipv4_header_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipv4hg_pkg::CfgIdxW-1:0]        cfg_index,
  input  ipv4hg_pkg::word_t                     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ipv4hg_pkg::word_t                     dest_addr,
  input  logic [7:0]                            protocol_num,
  input  logic [15:0]                           payload_len,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ipv4hg_pkg::word_t                     header_word,
  output logic [2:0]                            word_index,
  output logic                                  last_word,
  output ipv4hg_pkg::word_t                     next_hop,
  output logic                                  dest_broadcast,
  output logic                                  length_error
);
  import ipv4hg_pkg::*;

  `include "ipv4_header_generator_defines.svh"

  word_t       local_ip;
  word_t       subnet_mask;
  word_t       gateway_ip;
  logic        loopback_mode;
  logic [15:0] ident;

  logic        in_q_valid;
  word_t       in_dest;
  logic [7:0]  in_proto;
  logic [15:0] in_len;

  logic        in_accept;
  logic        free;
  logic        load;
  hdr_t        built;

  assign cfg_ready = 1'b1;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip      <= '0;
      subnet_mask   <= '0;
      gateway_ip    <= '0;
      loopback_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgLocalIp:    local_ip      <= cfg_data;
        CfgSubnetMask: subnet_mask   <= cfg_data;
        CfgGatewayIp:  gateway_ip    <= cfg_data;
        CfgLoopback:   loopback_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: hold a request until the serializer frees up
  assign load      = in_q_valid && free;
  assign in_stall  = in_q_valid && !free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (load) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_dest  <= dest_addr;
      in_proto <= protocol_num;
      in_len   <= payload_len;
    end
  end

  // Advance the identification only for good headers
  always_ff @(posedge clk) begin
    if (rst) begin
      ident <= IdentReset;
    end else if (load && !built.err) begin
      ident <= ident + 16'd1;
    end
  end

  ipv4hg_hdr_build u_build (
    .dest_addr     (in_dest),
    .protocol_num  (in_proto),
    .payload_len   (in_len),
    .ident         (ident),
    .local_ip      (local_ip),
    .subnet_mask   (subnet_mask),
    .gateway_ip    (gateway_ip),
    .loopback_mode (loopback_mode),
    .hdr           (built)
  );

  ipv4hg_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .hdr_in         (built),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .header_word    (header_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .next_hop       (next_hop),
    .dest_broadcast (dest_broadcast),
    .length_error   (length_error)
  );

  // Error beats are single, zero, index-0 results
  `IPV4HG_ASSERT(a_err_beat, (out_valid && length_error) |-> (last_word && word_index == 3'd0 && header_word == '0))
  // A rejected request never advances the identification
  `IPV4HG_ASSERT(a_ident_hold, (load && built.err) |=> $stable(ident))
  // A waiting request stays until it moves to the serializer
  `IPV4HG_ASSERT(a_in_hold, (in_q_valid && !load) |=> in_q_valid)
  // Loading only happens into an empty or finishing serializer
  `IPV4HG_ASSERT_ALWAYS(a_load_free, load |-> (!out_valid || (!out_stall && last_word)))

endmodule
